### hw/rtl/mptsd_pkg.sv
// Shared constants, register codes and sequencer states of the segment distance block
`timescale 1ns / 1ps
`default_nettype none

package mptsd_pkg;

   // default coordinate width
   localparam int COORD_WIDTH_DEF = 18;

   // distance result format
   localparam int DIST_W = 19;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // result tdata: point_distance, min_dist, zero fill to whole bytes
   localparam int RSP_DATA_W = ((2 * DIST_W + 7) / 8) * 8;

   // projection fraction t: 16 fractional bits, range 0 to one
   localparam int T_FRAC = 16;
   localparam int T_W = T_FRAC + 1;
   localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC{1'b0}}};

   // configuration register indexes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] REG_SEG_START_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SEG_START_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SEG_END_X = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SEG_END_Y = 2'd3;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL1,
      ST_SUM1,
      ST_SUM2,
      ST_CLAMP,
      ST_DIV,
      ST_TLAUNCH,
      ST_TMUL,
      ST_RES1,
      ST_RES2,
      ST_RES3,
      ST_SQMUL,
      ST_SSUM,
      ST_ROOT,
      ST_FIN
   } state_type;

endpackage : mptsd_pkg

`default_nettype wire

### hw/rtl/mptsd_mul.sv
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module mptsd_mul #(
   parameter int AW = 8,
   parameter int BW = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [AW-1:0]    a,
   input  wire logic [BW-1:0]    b,
   output logic                  done,
   output logic [AW+BW-1:0]      product
);

   localparam int CW = (BW > 1) ? $clog2(BW) : 1;

   logic [AW+BW-1:0] prod_ff, prod_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [AW:0]      sum;

   // one partial product per cycle, multiplier bits shift out at the bottom
   always_comb begin
      sum = {1'b0, prod_ff[AW+BW-1:BW]} + (prod_ff[0] ? {1'b0, a_ff} : {(AW+1){1'b0}});
      prod_in = prod_ff;
      a_in = a_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = {{AW{1'b0}}, b};
         a_in = a;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[BW-1:1]};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // operand and product
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff <= a_in;
   end

   assign done = done_ff;
   assign product = prod_ff;

endmodule : mptsd_mul

`default_nettype wire

### hw/rtl/mptsd_div.sv
// Restoring divider, one quotient bit per cycle, for a dividend below the divisor
`timescale 1ns / 1ps
`default_nettype none

module mptsd_div #(
   parameter int NW = 8,
   parameter int QW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [NW-1:0] den,
   output logic               done,
   output logic [QW-1:0]      quotient
);

   localparam int CW = (QW > 1) ? $clog2(QW) : 1;

   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] den_ff, den_in;
   logic [QW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW:0]   rem_sh;
   logic [NW:0]   diff;
   logic          ge;

   // shift, trial subtract, keep or restore
   always_comb begin
      rem_sh = {rem_ff, 1'b0};
      diff = rem_sh - {1'b0, den_ff};
      ge = (rem_sh >= {1'b0, den_ff});
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num;
         den_in = den;
         q_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[NW-1:0] : rem_sh[NW-1:0];
         q_in = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // remainder, divisor and quotient
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;

endmodule : mptsd_div

`default_nettype wire

### hw/rtl/mptsd_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle, truncated result
`timescale 1ns / 1ps
`default_nettype none

module mptsd_sqrt #(
   parameter int SW = 19
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [2*SW-1:0] radicand,
   output logic                 done,
   output logic [SW-1:0]        root
);

   localparam int CW = $clog2(SW);

   logic [2*SW-1:0] rad_ff, rad_in;
   logic [SW-1:0]   rem_ff, rem_in;
   logic [SW-1:0]   root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SW+1:0]   rem_sh;
   logic [SW+1:0]   trial;
   logic [SW+1:0]   diff;
   logic            ge;

   // bring in the next radicand pair, try root*4+1
   always_comb begin
      rem_sh = {rem_ff, rad_ff[2*SW-1:2*SW-2]};
      trial = {root_ff, 2'b01};
      diff = rem_sh - trial;
      ge = (rem_sh >= trial);
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in = radicand;
         rem_in = '0;
         root_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[2*SW-3:0], 2'b00};
         rem_in = ge ? diff[SW-1:0] : rem_sh[SW-1:0];
         root_in = {root_ff[SW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(SW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // radicand shift line, partial remainder and root
   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule : mptsd_sqrt

`default_nettype wire

### hw/rtl/min_point_to_segment_distance.sv
// Top level: point to segment distance with running minimum over a polyline
//
// Each point transfer on the req channel is measured against the segment held in the
// csr registers; one rsp transfer follows with the truncated Euclidean distance in
// 1/256 m units, saturated at 524287, and the running minimum, which returns to
// 524287 after a point marked last. One point is processed at a time. The result
// waits on the bit-serial multipliers (one multiplier bit per cycle: the squared
// length and dot product, then t times the direction, then the squared residuals),
// the 16-step divider for t, which is skipped when the projection clamps to an end
// of the segment or the segment has zero length, and the square root, which yields
// one result bit per cycle. The next point is taken as soon as a result has moved
// into the output register, even if it is still waiting. Segment registers may
// only be written while no point is in progress.
`timescale 1ns / 1ps
`default_nettype none

module min_point_to_segment_distance import mptsd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // point channel
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // from bit 0: point_x, point_y, zero fill
   input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   // last_point
   input  wire logic                                   req_tlast,
   // result channel
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // from bit 0: point_distance, min_dist, zero fill
   output logic [RSP_DATA_W-1:0]                       rsp_tdata,
   // is_last
   output logic                                        rsp_tlast,
   // segment register write port
   input  wire logic                                   csr_we,
   input  wire logic [CSR_ADDR_W-1:0]                  csr_addr,
   input  wire logic [COORD_WIDTH-1:0]                 csr_wdata
);

   localparam int W = COORD_WIDTH;
   localparam int MW = W + 1;                 // magnitude of a coordinate difference
   localparam int P1W = 2 * MW;               // squared length and dot product terms
   localparam int NW = P1W + 1;               // signed dot product
   localparam int P2W = MW + T_W;             // t times direction
   localparam int RSW = P2W + 1;              // signed residual
   localparam int RMW = P2W;                  // residual magnitude
   localparam int P3W = 2 * RMW;              // squared residual
   localparam int D2W = P3W + 1;              // sum of squared residuals
   localparam int VW = D2W - 2 * T_FRAC;      // squared distance in coordinate units
   localparam int SW = ((VW + 1) / 2 > DIST_W) ? (VW + 1) / 2 : DIST_W;

   // segment registers
   logic [W-1:0] seg_sx_ff, seg_sy_ff, seg_ex_ff, seg_ey_ff;

   // sequencer
   state_type state_ff, state_in;

   // point under work
   logic [W-1:0] px_ff, py_ff;
   logic         last_ff;

   // differences as magnitude and sign
   logic [MW-1:0] mdx_ff, mdy_ff, max_ff, may_ff;
   logic          sdx_ff, sdy_ff, sax_ff, say_ff;
   logic [MW-1:0] dx_c, dy_c, ax_c, ay_c;
   logic [MW-1:0] mdx_c, mdy_c, max_c, may_c;

   // squared length, dot product terms and fraction
   logic [P1W-1:0] len_ff;
   logic [NW-1:0]  termx_ff, termy_ff, num_ff;
   logic [T_W-1:0] t_ff;
   logic           num_le0, len_zero, num_ge_len, go_div;

   // residual
   logic [RSW-1:0] ashx_ff, ashy_ff, tdx_ff, tdy_ff, rx_ff, ry_ff;
   logic [RSW-1:0] ashx_c, ashy_c, tdx_c, tdy_c, rxn_c, ryn_c;
   logic [RMW-1:0] mrx_c, mry_c;
   logic [D2W-1:0] d2_c;

   // unit results
   logic [P1W-1:0] p_lx, p_ly, p_nx, p_ny;
   logic [P2W-1:0] p_tx, p_ty;
   logic [P3W-1:0] p_sx, p_sy;
   logic [T_FRAC-1:0] q_div;
   logic [SW-1:0]  root;
   logic           dn_lx, dn_ly, dn_nx, dn_ny, dn_tx, dn_ty, dn_sx, dn_sy;
   logic           dn_div, dn_sqrt;
   logic           mul1_done, mul2_done, mul3_done;

   // sequencer outputs
   logic mul1_start, div_start, mul2_start, mul3_start, sqrt_start;
   logic req_accept, rsp_load, out_free;

   // result side
   logic [DIST_W-1:0] running_min_ff;
   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_min_ff;
   logic              rsp_last_ff;
   logic [DIST_W-1:0] dist_c, min_c;

   // segment register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_sx_ff <= '0;
         seg_sy_ff <= '0;
         seg_ex_ff <= '0;
         seg_ey_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_SEG_START_X: seg_sx_ff <= csr_wdata;
            REG_SEG_START_Y: seg_sy_ff <= csr_wdata;
            REG_SEG_END_X:   seg_ex_ff <= csr_wdata;
            REG_SEG_END_Y:   seg_ey_ff <= csr_wdata;
         endcase
      end
   end

   // coordinate differences, sign extended by one bit
   always_comb begin
      dx_c = {seg_ex_ff[W-1], seg_ex_ff} - {seg_sx_ff[W-1], seg_sx_ff};
      dy_c = {seg_ey_ff[W-1], seg_ey_ff} - {seg_sy_ff[W-1], seg_sy_ff};
      ax_c = {px_ff[W-1], px_ff} - {seg_sx_ff[W-1], seg_sx_ff};
      ay_c = {py_ff[W-1], py_ff} - {seg_sy_ff[W-1], seg_sy_ff};
      mdx_c = dx_c[MW-1] ? (~dx_c + MW'(1)) : dx_c;
      mdy_c = dy_c[MW-1] ? (~dy_c + MW'(1)) : dy_c;
      max_c = ax_c[MW-1] ? (~ax_c + MW'(1)) : ax_c;
      may_c = ay_c[MW-1] ? (~ay_c + MW'(1)) : ay_c;
   end

   // clamp decisions on the dot product
   always_comb begin
      num_le0 = num_ff[NW-1] || (num_ff == '0);
      len_zero = (len_ff == '0);
      num_ge_len = (num_ff >= {1'b0, len_ff});
      go_div = !num_le0 && !len_zero && !num_ge_len;
   end

   // residual terms: A scaled by one in t units, and t times D, both signed
   always_comb begin
      ashx_c = sax_ff ? (~RSW'({max_ff, {T_FRAC{1'b0}}}) + RSW'(1))
                      : RSW'({max_ff, {T_FRAC{1'b0}}});
      ashy_c = say_ff ? (~RSW'({may_ff, {T_FRAC{1'b0}}}) + RSW'(1))
                      : RSW'({may_ff, {T_FRAC{1'b0}}});
      tdx_c = sdx_ff ? (~{1'b0, p_tx} + RSW'(1)) : {1'b0, p_tx};
      tdy_c = sdy_ff ? (~{1'b0, p_ty} + RSW'(1)) : {1'b0, p_ty};
      rxn_c = ~rx_ff + RSW'(1);
      ryn_c = ~ry_ff + RSW'(1);
      mrx_c = rx_ff[RSW-1] ? rxn_c[RMW-1:0] : rx_ff[RMW-1:0];
      mry_c = ry_ff[RSW-1] ? ryn_c[RMW-1:0] : ry_ff[RMW-1:0];
      d2_c = {1'b0, p_sx} + {1'b0, p_sy};
   end

   // saturate the root and fold it into the running minimum
   always_comb begin
      dist_c = (root > SW'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];
      min_c = (dist_c < running_min_ff) ? dist_c : running_min_ff;
   end

   assign mul1_done = dn_lx & dn_ly & dn_nx & dn_ny;
   assign mul2_done = dn_tx & dn_ty;
   assign mul3_done = dn_sx & dn_sy;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_MUL1;
         ST_MUL1:    if (mul1_done) state_in = ST_SUM1;
         ST_SUM1:    state_in = ST_SUM2;
         ST_SUM2:    state_in = ST_CLAMP;
         ST_CLAMP:   state_in = go_div ? ST_DIV : ST_TLAUNCH;
         ST_DIV:     if (dn_div) state_in = ST_TLAUNCH;
         ST_TLAUNCH: state_in = ST_TMUL;
         ST_TMUL:    if (mul2_done) state_in = ST_RES1;
         ST_RES1:    state_in = ST_RES2;
         ST_RES2:    state_in = ST_RES3;
         ST_RES3:    state_in = ST_SQMUL;
         ST_SQMUL:   if (mul3_done) state_in = ST_SSUM;
         ST_SSUM:    state_in = ST_ROOT;
         ST_ROOT:    if (dn_sqrt) state_in = ST_FIN;
         ST_FIN:     if (out_free) state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      mul1_start = (state_ff == ST_DIFF);
      div_start = (state_ff == ST_CLAMP) && go_div;
      mul2_start = (state_ff == ST_TLAUNCH);
      mul3_start = (state_ff == ST_RES3);
      sqrt_start = (state_ff == ST_SSUM);
      rsp_load = (state_ff == ST_FIN) && out_free;
   end

   assign req_accept = req_tvalid && req_tready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         running_min_ff <= DIST_MAX;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            running_min_ff <= last_ff ? DIST_MAX : min_c;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         px_ff <= req_tdata[W-1:0];
         py_ff <= req_tdata[2*W-1:W];
         last_ff <= req_tlast;
      end
      if (state_ff == ST_DIFF) begin
         mdx_ff <= mdx_c;
         mdy_ff <= mdy_c;
         max_ff <= max_c;
         may_ff <= may_c;
         sdx_ff <= dx_c[MW-1];
         sdy_ff <= dy_c[MW-1];
         sax_ff <= ax_c[MW-1];
         say_ff <= ay_c[MW-1];
      end
      if (state_ff == ST_SUM1) begin
         len_ff <= p_lx + p_ly;
         termx_ff <= (sax_ff ^ sdx_ff) ? (~{1'b0, p_nx} + NW'(1)) : {1'b0, p_nx};
         termy_ff <= (say_ff ^ sdy_ff) ? (~{1'b0, p_ny} + NW'(1)) : {1'b0, p_ny};
      end
      if (state_ff == ST_SUM2) begin
         num_ff <= termx_ff + termy_ff;
      end
      // t: zero, one, or the quotient
      if (state_ff == ST_CLAMP) begin
         t_ff <= (num_le0 || len_zero) ? '0 : T_ONE;
      end else if ((state_ff == ST_DIV) && dn_div) begin
         t_ff <= {1'b0, q_div};
      end
      if (state_ff == ST_RES1) begin
         ashx_ff <= ashx_c;
         ashy_ff <= ashy_c;
         tdx_ff <= tdx_c;
         tdy_ff <= tdy_c;
      end
      if (state_ff == ST_RES2) begin
         rx_ff <= ashx_ff - tdx_ff;
         ry_ff <= ashy_ff - tdy_ff;
      end
      if (rsp_load) begin
         rsp_dist_ff <= dist_c;
         rsp_min_ff <= min_c;
         rsp_last_ff <= last_ff;
      end
   end

   // squared length and dot product terms
   mptsd_mul #(.AW(MW), .BW(MW)) u_mul_lx (
      .clock(clock), .reset(reset), .start(mul1_start),
      .a(mdx_c), .b(mdx_c), .done(dn_lx), .product(p_lx)
   );
   mptsd_mul #(.AW(MW), .BW(MW)) u_mul_ly (
      .clock(clock), .reset(reset), .start(mul1_start),
      .a(mdy_c), .b(mdy_c), .done(dn_ly), .product(p_ly)
   );
   mptsd_mul #(.AW(MW), .BW(MW)) u_mul_nx (
      .clock(clock), .reset(reset), .start(mul1_start),
      .a(max_c), .b(mdx_c), .done(dn_nx), .product(p_nx)
   );
   mptsd_mul #(.AW(MW), .BW(MW)) u_mul_ny (
      .clock(clock), .reset(reset), .start(mul1_start),
      .a(may_c), .b(mdy_c), .done(dn_ny), .product(p_ny)
   );

   // projection fraction
   mptsd_div #(.NW(P1W), .QW(T_FRAC)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(num_ff[P1W-1:0]), .den(len_ff), .done(dn_div), .quotient(q_div)
   );

   // t times direction
   mptsd_mul #(.AW(MW), .BW(T_W)) u_mul_tx (
      .clock(clock), .reset(reset), .start(mul2_start),
      .a(mdx_ff), .b(t_ff), .done(dn_tx), .product(p_tx)
   );
   mptsd_mul #(.AW(MW), .BW(T_W)) u_mul_ty (
      .clock(clock), .reset(reset), .start(mul2_start),
      .a(mdy_ff), .b(t_ff), .done(dn_ty), .product(p_ty)
   );

   // squared residuals
   mptsd_mul #(.AW(RMW), .BW(RMW)) u_mul_sx (
      .clock(clock), .reset(reset), .start(mul3_start),
      .a(mrx_c), .b(mrx_c), .done(dn_sx), .product(p_sx)
   );
   mptsd_mul #(.AW(RMW), .BW(RMW)) u_mul_sy (
      .clock(clock), .reset(reset), .start(mul3_start),
      .a(mry_c), .b(mry_c), .done(dn_sy), .product(p_sy)
   );

   // distance root, radicand scaled back to coordinate units
   mptsd_sqrt #(.SW(SW)) u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start),
      .radicand((2 * SW)'(d2_c[D2W-1:2*T_FRAC])), .done(dn_sqrt), .root(root)
   );

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - 2 * DIST_W){1'b0}}, rsp_min_ff, rsp_dist_ff};
   assign rsp_tlast = rsp_last_ff;

endmodule : min_point_to_segment_distance

`default_nettype wire

### hw/rtl/mptsd_checker.sv
// Port-level checker for the segment distance block, with its bind
`timescale 1ns / 1ps
`default_nettype none

module mptsd_checker import mptsd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input wire logic                               req_tlast,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [RSP_DATA_W-1:0]              rsp_tdata,
   input wire logic                               rsp_tlast,
   input wire logic                               csr_we,
   input wire logic [CSR_ADDR_W-1:0]              csr_addr,
   input wire logic [COORD_WIDTH-1:0]             csr_wdata
);

   logic [1:0]        pending_ff;
   logic              open_ff;
   logic [DIST_W-1:0] prev_min_ff;
   logic              in_xfer, out_xfer;
   logic [DIST_W-1:0] rsp_dist, rsp_min;

   assign in_xfer = req_tvalid && req_tready;
   assign out_xfer = rsp_tvalid && rsp_tready;
   assign rsp_dist = rsp_tdata[DIST_W-1:0];
   assign rsp_min = rsp_tdata[2*DIST_W-1:DIST_W];

   // points accepted but not yet delivered, and the minimum of the open polyline
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         open_ff <= 1'b0;
         prev_min_ff <= DIST_MAX;
      end else begin
         pending_ff <= pending_ff + {1'b0, in_xfer} - {1'b0, out_xfer};
         if (out_xfer) begin
            open_ff <= !rsp_tlast;
            prev_min_ff <= rsp_min;
         end
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // running minimum never above this point's distance
   a_min_le_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_min <= rsp_dist)
      else $error("minimum above point distance");

   // within a polyline the minimum never grows
   a_min_monotone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && open_ff |-> rsp_min <= prev_min_ff)
      else $error("running minimum grew inside a polyline");

   // no result without a point behind it
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("result without accepted point");

   // one point at work plus one waiting result at most
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 2'd2)
      else $error("too many points in flight");

endmodule : mptsd_checker

bind min_point_to_segment_distance mptsd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);

`default_nettype wire

### sim/tb_min_point_to_segment_distance.sv
// Testbench for the point to segment distance block: directed and randomised polylines checked against a scoreboard
`timescale 1ns / 1ps

module tb_min_point_to_segment_distance import mptsd_pkg::*;;

   localparam int COORD_W = COORD_WIDTH_DEF;
   localparam int REQ_DATA_W = ((2 * COORD_W + 7) / 8) * 8;
   localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
   localparam int COORD_MIN = -(1 << (COORD_W - 1));
   // accept to result, worst case, in clock cycles
   localparam int LATENCY = 2 * COORD_W + ((COORD_W + 3 > 19) ? COORD_W + 3 : 19) + 67;
   localparam int SETTLE = LATENCY + 10;
   localparam int PHASE_POINTS = 92;
   localparam int NUM_PHASES = 8;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic [DIST_W-1:0] min_dist;
      logic              is_last;
   } dist_result_type;

   // segment copy, running minimum and the queue of predicted results
   class dist_scoreboard_type;
      logic signed [COORD_W-1:0] start_x, start_y, end_x, end_y;
      logic [DIST_W-1:0] running_min;
      dist_result_type expected_q[$];
      int errors;

      function new();
         start_x = '0;
         start_y = '0;
         end_x = '0;
         end_y = '0;
         running_min = DIST_MAX;
         errors = 0;
      endfunction

      function void set_register(logic [CSR_ADDR_W-1:0] idx, logic [COORD_W-1:0] value);
         case (idx)
            REG_SEG_START_X: start_x = value;
            REG_SEG_START_Y: start_y = value;
            REG_SEG_END_X:   end_x = value;
            REG_SEG_END_Y:   end_y = value;
            default: ;
         endcase
      endfunction

      // project the point, clamp t, then truncated root of the squared residual
      function void note_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                               logic last);
         longint sx, sy, dx, dy, ax, ay, len_sq, dot, frac_t, res_x, res_y;
         logic signed [127:0] wide_x, wide_y;
         logic [127:0] sq_sum;
         longint unsigned sq_top, root, cand;
         dist_result_type r;
         sx = start_x;
         sy = start_y;
         dx = end_x;
         dy = end_y;
         dx = dx - sx;
         dy = dy - sy;
         ax = px;
         ay = py;
         ax = ax - sx;
         ay = ay - sy;
         len_sq = dx * dx + dy * dy;
         dot = ax * dx + ay * dy;
         if (len_sq == 0 || dot <= 0) begin
            frac_t = 0;
         end else if (dot >= len_sq) begin
            frac_t = 65536;
         end else begin
            frac_t = (dot * 65536) / len_sq;
         end
         res_x = ax * 65536 - frac_t * dx;
         res_y = ay * 65536 - frac_t * dy;
         wide_x = res_x;
         wide_y = res_y;
         sq_sum = wide_x * wide_x + wide_y * wide_y;
         sq_top = sq_sum[95:32];
         root = 0;
         for (int b = 23; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= sq_top) root = cand;
         end
         r.distance = (root > DIST_MAX) ? DIST_MAX : root[DIST_W-1:0];
         r.min_dist = (r.distance < running_min) ? r.distance : running_min;
         r.is_last = last;
         running_min = last ? DIST_MAX : r.min_dist;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [DIST_W-1:0] distance, logic [DIST_W-1:0] min_dist,
                                 logic is_last);
         dist_result_type r;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result: distance %0d min %0d last %0b", $time,
                     distance, min_dist, is_last);
            return;
         end
         r = expected_q.pop_front();
         if (distance !== r.distance) begin
            errors++;
            $display("%0t point_distance mismatch: expected %0d, actual %0d", $time,
                     r.distance, distance);
         end
         if (min_dist !== r.min_dist) begin
            errors++;
            $display("%0t running minimum mismatch: expected %0d, actual %0d", $time,
                     r.min_dist, min_dist);
         end
         if (is_last !== r.is_last) begin
            errors++;
            $display("%0t is_last mismatch: expected %0b, actual %0b", $time,
                     r.is_last, is_last);
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_we;
   logic [CSR_ADDR_W-1:0]   csr_addr;
   logic [COORD_W-1:0]      csr_wdata;

   dist_scoreboard_type sb = new();
   int idle_pct;

   min_point_to_segment_distance #(
      .COORD_WIDTH(COORD_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // overall time limit
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // result transfers go to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata[DIST_W-1:0], rsp_tdata[2*DIST_W-1:DIST_W], rsp_tlast);
      end
   end

   // receiver back-pressure in random bursts
   initial begin
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   function automatic int rand_coord();
      return int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
   endfunction

   // point around the segment at fraction frac/256, spread either side, kept in range
   function automatic int near_coord(int s, int e, int frac, int spread);
      int v;
      v = s + ((e - s) * frac) / 256 + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v;
   endfunction

   // one point transfer, then an optional gap with tvalid low
   task automatic send_point(int x, int y, logic last);
      int bursts;
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - 2 * COORD_W){1'b0}}, y[COORD_W-1:0], x[COORD_W-1:0]};
      req_tlast <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sb.note_point(x[COORD_W-1:0], y[COORD_W-1:0], last);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         bursts = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 10) : 1;
         repeat (bursts) repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // stop sending, then hold off until every result is back and the pipeline has emptied
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write all four segment registers on consecutive edges
   task automatic program_segment(int sx, int sy, int ex, int ey);
      logic [CSR_ADDR_W-1:0] idx[4];
      logic [COORD_W-1:0] vals[4];
      idx[0] = REG_SEG_START_X;
      idx[1] = REG_SEG_START_Y;
      idx[2] = REG_SEG_END_X;
      idx[3] = REG_SEG_END_Y;
      vals[0] = sx[COORD_W-1:0];
      vals[1] = sy[COORD_W-1:0];
      vals[2] = ex[COORD_W-1:0];
      vals[3] = ey[COORD_W-1:0];
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_addr <= idx[i];
         csr_wdata <= vals[i];
         sb.set_register(idx[i], vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int sx, sy, ex, ey, x, y, frac, spread, plen, count;
      logic broken, last;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_we <= 1'b0;
      csr_addr <= REG_SEG_START_X;
      csr_wdata <= '0;
      idle_pct = 30;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero-length segment at the origin straight after reset, coordinate extremes
      send_point(0, 0, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 1'b0);
      send_point(COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MIN, COORD_MAX, 1'b1);
      wait_idle();

      // full-range diagonal segment
      program_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_point(COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MIN, COORD_MAX, 1'b0);
      send_point(0, 0, 1'b1);
      wait_idle();

      // short segment: clamp at both ends, zero dot product, dot equal to length
      program_segment(0, 0, 1000, 0);
      send_point(-5000, 300, 1'b0);
      send_point(0, 500, 1'b0);
      send_point(1000, 5, 1'b0);
      send_point(8000, -300, 1'b0);
      send_point(500, 77, 1'b0);
      send_point(333, -1, 1'b1);
      wait_idle();

      // zero-length segment in a corner, farthest point
      program_segment(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
      send_point(COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MIN, COORD_MAX, 1'b1);
      wait_idle();

      // skewed segment, back-to-back last points
      program_segment(100, -50, -7, 9999);
      send_point(40, 5000, 1'b0);
      send_point(-3000, 12000, 1'b0);
      send_point(200, -4000, 1'b1);
      send_point(55, 2500, 1'b1);
      send_point(-131, 7777, 1'b0);
      wait_idle();

      // random phases: new segment each time, mostly polylines near it
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase % 4)
            0: begin
               sx = rand_coord();
               sy = rand_coord();
               ex = rand_coord();
               ey = rand_coord();
            end
            1: begin
               sx = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
               sy = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
               ex = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
               ey = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            end
            2: begin
               sx = rand_coord();
               sy = rand_coord();
               ex = sx;
               ey = sy;
            end
            default: begin
               sx = int'($urandom_range(0, 200000)) - 100000;
               sy = int'($urandom_range(0, 200000)) - 100000;
               ex = sx + int'($urandom_range(0, 64)) - 32;
               ey = sy + int'($urandom_range(0, 64)) - 32;
            end
         endcase
         program_segment(sx, sy, ex, ey);
         if (phase == NUM_PHASES - 1 || phase == 3) idle_pct = 0;
         else idle_pct = $urandom_range(0, 1) ? 20 : 50;

         count = 0;
         while (count < PHASE_POINTS) begin
            plen = $urandom_range(1, 24);
            spread = 1 << $urandom_range(0, COORD_W - 1);
            broken = ($urandom_range(0, 9) == 0);
            for (int j = 0; j < plen && count < PHASE_POINTS; j++) begin
               if ($urandom_range(0, 7) == 0) begin
                  x = rand_coord();
                  y = rand_coord();
               end else begin
                  frac = int'($urandom_range(0, 384)) - 64;
                  x = near_coord(sx, ex, frac, spread);
                  y = near_coord(sy, ey, frac, spread);
               end
               last = broken ? 1'($urandom_range(0, 1)) : (j == plen - 1);
               send_point(x, y, last);
               count++;
            end
         end
         wait_idle();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (sb.expected_q.size() != 0)
            $display("%0t %0d expected results never arrived", $time, sb.expected_q.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/mptsd_pkg.sv
hw/rtl/mptsd_mul.sv
hw/rtl/mptsd_div.sv
hw/rtl/mptsd_sqrt.sv
hw/rtl/min_point_to_segment_distance.sv
hw/rtl/mptsd_checker.sv
sim/tb_min_point_to_segment_distance.sv
